@@ design/fts_pkg.sv @@
`default_nettype none
package fts_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 2);
  localparam int EMIT_MAX = (MAX_ELEMENTS < 16) ? MAX_ELEMENTS : 16;
  localparam int ELEM_W = 32;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    elem_t data;
  } mem_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_SORT_PLACE,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_t;

endpackage
`default_nettype wire

@@ design/find_then_sort_suffix_unit.sv @@
`default_nettype none
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  req_type, data
// out      output     out_valid/out_ready  found, match_index, elem_index, elem_value, last
//
// append and clear do not leave ST_IDLE; the block is ready again in the next cycle
// a search scans for the first match, then insertion-sorts the suffix after it
// through the one element memory (one read and one write port),
// then emits each beat via ST_EMIT_RD and ST_EMIT_WAIT, plus any stall on out_ready
// rst clears the element count; the element memory holds no reset
// in_ready is low for the whole of a search, until its last beat is taken
module find_then_sort_suffix_unit
  import fts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire elem_t       data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output logic [3:0]       match_index,
  output logic [3:0]       elem_index,
  output elem_t            elem_value,
  output logic             last
);

  state_t  state;
  state_t  state_next;
  cnt_t    count;
  cnt_t    i;
  cnt_t    j;
  cnt_t    lo;
  cnt_t    e;
  cnt_t    pos;
  elem_t   key;
  elem_t   kv;
  logic    hit;
  logic    empty_run;

  mem_wr_t wr;
  idx_t    rd_addr;
  elem_t   rd_data;

  cnt_t    i_p1;
  cnt_t    i_p2;
  cnt_t    j_m1;
  cnt_t    j_m2;
  cnt_t    emit_lim;
  logic    in_beat;
  logic    out_beat;
  logic    is_match;
  logic    is_gt;
  logic    more_keys;

  fts_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign i_p1      = i + cnt_t'(1);
  assign i_p2      = i + cnt_t'(2);
  assign j_m1      = j - cnt_t'(1);
  assign j_m2      = j - cnt_t'(2);
  assign emit_lim  = (count > cnt_t'(EMIT_MAX)) ? cnt_t'(EMIT_MAX) : count;
  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;
  assign is_match  = (rd_data == key);
  assign is_gt     = (rd_data > kv);
  assign more_keys = (i_p1 < count);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat && req_type == REQ_SEARCH) begin
          state_next = (count == '0) ? ST_EMIT_WAIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (is_match) begin
          state_next = (i_p2 < count) ? ST_SORT_KEY : ST_EMIT_RD;
        end else if (i_p1 == count) begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_SORT_KEY: begin
        state_next = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        if (is_gt) begin
          state_next = (j_m1 > lo) ? ST_SORT_CMP : ST_SORT_PLACE;
        end else begin
          state_next = more_keys ? ST_SORT_KEY : ST_EMIT_RD;
        end
      end
      ST_SORT_PLACE: begin
        state_next = more_keys ? ST_SORT_KEY : ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_beat) begin
          state_next = last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // memory port and handshake
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    rd_addr   = '0;
    wr.en     = 1'b0;
    wr.addr   = j[IDX_W-1:0];
    wr.data   = kv;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        wr.addr  = count[IDX_W-1:0];
        wr.data  = data;
        wr.en    = in_beat && req_type == REQ_APPEND && count < cnt_t'(MAX_ELEMENTS);
      end
      ST_SCAN: begin
        rd_addr = is_match ? i_p2[IDX_W-1:0] : i_p1[IDX_W-1:0];
      end
      ST_SORT_KEY: begin
        rd_addr = i_p1[IDX_W-1:0] - idx_t'(2);
      end
      ST_SORT_CMP: begin
        wr.en = 1'b1;
        if (is_gt) begin
          wr.data = rd_data;
          rd_addr = j_m2[IDX_W-1:0];
        end else begin
          rd_addr = i_p1[IDX_W-1:0];
        end
      end
      ST_SORT_PLACE: begin
        wr.en   = 1'b1;
        rd_addr = i_p1[IDX_W-1:0];
      end
      ST_EMIT_RD: begin
        rd_addr = e[IDX_W-1:0];
      end
      ST_EMIT_WAIT: begin
        out_valid = 1'b1;
        rd_addr   = e[IDX_W-1:0];
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_beat) begin
        if (req_type == REQ_APPEND && count < cnt_t'(MAX_ELEMENTS)) begin
          count <= count + cnt_t'(1);
        end else if (req_type == REQ_CLEAR) begin
          count <= '0;
        end
      end
    end
  end

  // search and sort datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        key       <= data;
        hit       <= 1'b0;
        pos       <= '0;
        e         <= '0;
        i         <= '0;
        empty_run <= (count == '0);
      end
      ST_SCAN: begin
        if (is_match) begin
          hit <= 1'b1;
          pos <= i;
          lo  <= i_p1;
          i   <= i_p2;
        end else begin
          i <= i_p1;
        end
      end
      ST_SORT_KEY: begin
        kv <= rd_data;
        j  <= i;
      end
      ST_SORT_CMP: begin
        if (is_gt) begin
          j <= j_m1;
        end else begin
          i <= i_p1;
        end
      end
      ST_SORT_PLACE: begin
        i <= i_p1;
      end
      ST_EMIT_WAIT: begin
        if (out_beat) begin
          e <= e + cnt_t'(1);
        end
      end
      default: begin
        e <= e;
      end
    endcase
  end

  assign found       = hit;
  assign match_index = hit ? 4'(pos) : 4'd0;
  assign elem_index  = 4'(e);
  assign elem_value  = empty_run ? elem_t'(0) : rd_data;
  assign last        = empty_run || (e + cnt_t'(1) == emit_lim);

endmodule
`default_nettype wire

@@ design/fts_mem.sv @@
`default_nettype none
module fts_mem
  import fts_pkg::*;
(
  input  wire logic    clk,
  input  wire mem_wr_t wr,
  input  wire idx_t    rd_addr,
  output elem_t        rd_data
);

  elem_t store [MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[wr.addr] <= wr.data;
    end
    rd_data <= store[rd_addr];
  end

endmodule
`default_nettype wire
